/* rtl/wpac_pkg.sv */
// Shared constants and types for the waterfall peak-AGC colorizer.
// Holds register indexes, reset values, threshold factors and the pixel record.
// No dependencies.
package wpac_pkg;

    // Geometry and datapath widths
    localparam int COLUMNS_DEF = 320;
    localparam int MAG_W       = 16;
    localparam int COLOR_W     = 16;
    localparam int COLOUT_W    = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int THR_W       = 33;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_FIVE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_FOUR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ONE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BG    = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_DECAY       = 16'd64881;
    localparam logic [15:0] RST_COLOR_FIVE  = 16'd11338;
    localparam logic [15:0] RST_COLOR_FOUR  = 16'd65535;
    localparam logic [15:0] RST_COLOR_THREE = 16'd50712;
    localparam logic [15:0] RST_COLOR_TWO   = 16'd33808;
    localparam logic [15:0] RST_COLOR_ONE   = 16'd16904;
    localparam logic [15:0] RST_COLOR_BG    = 16'd0;

    // Q0.16 threshold factors, highest level first: (11^t - 1) / 10
    localparam logic [15:0] LEVEL_K [5] = '{16'd38073, 16'd28559, 16'd21072,
                                            16'd15182, 16'd10548};

    // Peak value used when the stored peak is zero (1.0 in Q0.16)
    localparam logic [16:0] PEAK_ONE = 17'h10000;

    // One colored pixel as queued for the output
    typedef struct packed {
        logic                last;
        logic [COLOUT_W-1:0] column;
        logic [COLOR_W-1:0]  color;
    } t_pixel;

endpackage

/* rtl/waterfall_peak_agc_colorizer_top.sv */
// Top level of the waterfall peak-AGC colorizer: row store, peak tracking,
// threshold coloring and output queue. Depends on wpac_pkg and wpac_ram.
//
// Each input transaction passes through stage 1 (store read), stage 2 (compare) and the output queue;
// m_axis_tvalid is high while the queue holds an item.
// Throughput: one item per cycle; one read-modify-write of the row store per item.
// s_axis_tready drops only when the 4-entry output queue plus items in flight are full.
// Reset (i_rst_n low, synchronous): peak, row maximum, column and config registers
// take their reset values; the store is not swept, the whole first row reads as zero.
module waterfall_peak_agc_colorizer_top #(
    parameter int COLUMNS = wpac_pkg::COLUMNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [15:0] magnitude
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // [15:0] pixel_color, [24:16] column
    output logic                            m_axis_tlast,  // last_in_row
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [wpac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wpac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int QP_W  = $clog2(wpac_pkg::QUEUE_DEPTH);
    localparam int QC_W  = $clog2(wpac_pkg::QUEUE_DEPTH + 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // Configuration registers
    logic [15:0] r_decay;
    logic [wpac_pkg::COLOR_W-1:0] r_color_five, r_color_four, r_color_three;
    logic [wpac_pkg::COLOR_W-1:0] r_color_two, r_color_one, r_color_bg;

    // Row tracking state
    logic [COL_W-1:0] r_col;
    logic [15:0]      r_peak, n_peak;
    logic [15:0]      r_row_max, n_row_max;
    logic             r_filled;

    // Pipeline stage 1 (store read in progress)
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_last;
    logic             r_s1_zero;
    logic [15:0]      r_s1_peak;

    // Pipeline stage 2 (compare)
    logic                         r_s2_valid;
    logic [15:0]                  r_s2_mag;
    logic [COL_W-1:0]             r_s2_col;
    logic                         r_s2_last;
    logic [wpac_pkg::THR_W-1:0]   r_s2_thr [5];

    // Output queue
    wpac_pkg::t_pixel r_queue [wpac_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QC_W-1:0]  r_q_cnt;
    logic [QC_W-1:0]  r_credit;

    logic             in_fire, out_fire, is_last;
    logic [15:0]      mag_in;
    logic [15:0]      ram_rdata;
    logic [15:0]      row_max_now;
    logic [31:0]      decay_prod;
    logic [16:0]      peak_eff;
    logic [wpac_pkg::THR_W-1:0] thr [5];
    logic [wpac_pkg::THR_W-1:0] scaled;
    logic [4:0]       above;
    logic [wpac_pkg::COLOR_W-1:0] color_sel;
    logic [COL_W+wpac_pkg::COLOUT_W-1:0] col_ext;
    wpac_pkg::t_pixel pix_new;

    assign mag_in        = s_axis_tdata[15:0];
    assign s_axis_tready = (r_credit < QC_W'(wpac_pkg::QUEUE_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign is_last       = (r_col == COL_LAST);

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay       <= wpac_pkg::RST_DECAY;
            r_color_five  <= wpac_pkg::RST_COLOR_FIVE;
            r_color_four  <= wpac_pkg::RST_COLOR_FOUR;
            r_color_three <= wpac_pkg::RST_COLOR_THREE;
            r_color_two   <= wpac_pkg::RST_COLOR_TWO;
            r_color_one   <= wpac_pkg::RST_COLOR_ONE;
            r_color_bg    <= wpac_pkg::RST_COLOR_BG;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wpac_pkg::REG_DECAY:       r_decay       <= i_cfg_data;
                wpac_pkg::REG_COLOR_FIVE:  r_color_five  <= i_cfg_data;
                wpac_pkg::REG_COLOR_FOUR:  r_color_four  <= i_cfg_data;
                wpac_pkg::REG_COLOR_THREE: r_color_three <= i_cfg_data;
                wpac_pkg::REG_COLOR_TWO:   r_color_two   <= i_cfg_data;
                wpac_pkg::REG_COLOR_ONE:   r_color_one   <= i_cfg_data;
                wpac_pkg::REG_COLOR_BG:    r_color_bg    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Row store: read the previous row's value, write the new one
    wpac_ram #(
        .WIDTH (16),
        .DEPTH (COLUMNS)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_en    (in_fire),
        .i_we    (in_fire),
        .i_addr  (r_col),
        .i_wdata (mag_in),
        .o_rdata (ram_rdata)
    );

    // Row maximum updates on every item; peak updates and row maximum clears at the end of a row
    assign row_max_now = (mag_in > r_row_max) ? mag_in : r_row_max;
    assign decay_prod  = r_peak * r_decay;

    always_comb begin
        n_row_max = r_row_max;
        n_peak    = r_peak;
        if (in_fire) begin
            if (is_last) begin
                n_row_max = '0;
                n_peak    = (row_max_now > r_peak) ? row_max_now : decay_prod[31:16];
            end else begin
                n_row_max = row_max_now;
            end
        end
    end

    // Row tracking and stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_peak     <= '0;
            r_row_max  <= '0;
            r_filled   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_peak     <= n_peak;
            r_row_max  <= n_row_max;
            r_s1_valid <= in_fire;
            if (in_fire) begin
                r_col <= is_last ? '0 : r_col + 1'b1;
                if (is_last) begin
                    r_filled <= 1'b1;
                end
            end
        end
    end

    // Stage 1 payload: hold the peak as it stood before this item
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_col  <= r_col;
            r_s1_last <= is_last;
            r_s1_zero <= !r_filled;
            r_s1_peak <= r_peak;
        end
    end

    // Thresholds from the item's peak, zero peak counts as 1.0
    assign peak_eff = (r_s1_peak == '0) ? wpac_pkg::PEAK_ONE : {1'b0, r_s1_peak};

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            thr[i] = peak_eff * wpac_pkg::LEVEL_K[i];
        end
    end

    // Stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_mag  <= r_s1_zero ? '0 : ram_rdata;
            r_s2_col  <= r_s1_col;
            r_s2_last <= r_s1_last;
            for (int i = 0; i < 5; i++) begin
                r_s2_thr[i] <= thr[i];
            end
        end
    end

    // Strict compares, highest level wins
    assign scaled = {1'b0, r_s2_mag, 16'd0};

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            above[i] = (scaled > r_s2_thr[i]);
        end
    end

    always_comb begin
        if (above[0]) begin
            color_sel = r_color_five;
        end else if (above[1]) begin
            color_sel = r_color_four;
        end else if (above[2]) begin
            color_sel = r_color_three;
        end else if (above[3]) begin
            color_sel = r_color_two;
        end else if (above[4]) begin
            color_sel = r_color_one;
        end else begin
            color_sel = r_color_bg;
        end
    end

    // Column field carries the low bits of the counter
    assign col_ext        = {{wpac_pkg::COLOUT_W{1'b0}}, r_s2_col};
    assign pix_new.last   = r_s2_last;
    assign pix_new.column = col_ext[wpac_pkg::COLOUT_W-1:0];
    assign pix_new.color  = color_sel;

    // Output queue control and credit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
            r_credit <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_cnt  <= r_q_cnt + QC_W'(r_s2_valid) - QC_W'(out_fire);
            r_credit <= r_credit + QC_W'(in_fire) - QC_W'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_queue[r_wr_ptr] <= pix_new;
        end
    end

    assign m_axis_tvalid = (r_q_cnt != '0);
    assign m_axis_tdata  = {7'd0, r_queue[r_rd_ptr].column, r_queue[r_rd_ptr].color};
    assign m_axis_tlast  = r_queue[r_rd_ptr].last;

    // Credit covers every item in flight or queued
    a_credit_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit == QC_W'(r_s1_valid) + QC_W'(r_s2_valid) + r_q_cnt)
        else $error("credit count out of step with pipeline and queue");

    // Queue never overflows
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= QC_W'(wpac_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    // Row maximum restarts after the last column
    a_row_max_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_last) |=> (r_row_max == '0) && (r_col == '0))
        else $error("row state not restarted after last column");

    // tlast marks the last column
    a_last_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_last) |-> (r_s2_col == COL_LAST))
        else $error("last flag on wrong column");

endmodule

/* rtl/wpac_ram.sv */
// Generic single-port synchronous RAM, read-first, registered read.
// Used for the row store of the waterfall colorizer. No dependencies.
module wpac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 320
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read old contents, then write
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
